FILE: design/ifr_pkg.sv
// ----------------------------------------------------------------------------
// ifr_pkg: shared types and constants of the idle timeout frame receiver
// Holds the register map, the input codes, the controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ifr_pkg;

    // Default depth of the frame buffer.
    localparam int BUFFER_DEPTH_DEFAULT = 32;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Register reset values.
    localparam logic [7:0]  IDLE_LIMIT_RESET  = 8'd5;
    localparam logic [15:0] LINK_LIMIT_RESET  = 16'd10000;
    localparam logic [7:0]  HEADER_BYTE_RESET = 8'hD5;
    localparam logic [15:0] CONC_FLOOR_RESET  = 16'd210;

    // Link counter saturation value.
    localparam logic [15:0] LINK_COUNT_MAX = 16'hFFFF;

    // Frame layout: five big-endian words from byte 3 on, then the key byte.
    localparam int N_FIELDS         = 5;
    localparam int FIELD_FIRST_BYTE = 3;
    localparam int KEY_BYTE         = 13;
    localparam int CAP_BYTES        = KEY_BYTE - FIELD_FIRST_BYTE + 1;

    // Register map.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IDLE_LIMIT  = 2'd0,
        CFG_LINK_LIMIT  = 2'd1,
        CFG_HEADER_BYTE = 2'd2,
        CFG_CONC_FLOOR  = 2'd3
    } cfg_idx_t;

    // Input item kinds carried on s_tuser.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } ifr_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic accept;
        logic walk_issue;
        logic finish;
    } ifr_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic close_frame;
        logic walk_end;
        logic out_free;
    } ifr_stat_t;

endpackage

FILE: design/ifr_ctrl.sv
// ----------------------------------------------------------------------------
// ifr_ctrl: sequencing controller of the frame receiver
// Accepts items while idle and walks the buffer when a tick closes a frame.
// ----------------------------------------------------------------------------
module ifr_ctrl
    import ifr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ifr_stat_t stat,
    output ifr_cmd_t  cmd
);

    ifr_state_t state_reg;
    ifr_state_t state_next;
    logic       take;

    // A transaction is taken in idle once the output register has room.
    assign take = (state_reg == ST_IDLE) && stat.out_free && s_tvalid;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take && stat.close_frame) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (stat.walk_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.walk_issue = 1'b0;
        cmd.finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = stat.out_free;
                cmd.accept = take;
            end
            ST_WALK:   cmd.walk_issue = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: cmd.finish = 1'b1;
            default:   ;
        endcase
    end

endmodule

FILE: design/ifr_dp.sv
// ----------------------------------------------------------------------------
// ifr_dp: datapath of the frame receiver
// Holds the configuration registers, the frame buffer, the idle and link
// counters, the checksum walk, the latched fields and the output register.
// ----------------------------------------------------------------------------
module ifr_dp
    import ifr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Item payload
    input  logic [7:0]             s_tdata,
    input  logic                   s_tuser,
    // Result register
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [87:0]            m_tdata,
    output logic [2:0]             m_tuser,
    // Configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Controller
    input  ifr_cmd_t               cmd,
    output ifr_stat_t              stat
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(BUFFER_DEPTH - 1);
    localparam logic [IDX_W-1:0] KEY_IDX   = IDX_W'(KEY_BYTE);

    // Configuration registers
    logic [7:0]  idle_limit_reg;
    logic [15:0] link_limit_reg;
    logic [7:0]  header_byte_reg;
    logic [15:0] conc_floor_reg;

    // Frame buffer with per-entry valid bits
    logic [7:0]              mem [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] vld_reg;

    // Frame and link state
    logic [IDX_W-1:0] count_reg;
    logic [7:0]       timer_reg;
    logic [15:0]      link_cnt_reg;
    logic             link_flag_reg;
    logic [15:0]      fields_reg [N_FIELDS];
    logic [7:0]       key_reg;

    // Checksum walk
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_idx_q_reg;
    logic             rd_dv_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] len_m1_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic [7:0]       sum_reg;
    logic [7:0]       hdr_reg;
    logic [7:0]       tail_reg;
    logic [7:0]       cap_reg [CAP_BYTES];

    // Output register
    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    // Combinational terms
    logic             is_tick;
    logic [15:0]      link_inc;
    logic             link_over;
    logic [8:0]       idle_inc;
    logic             close_frame;
    logic [IDX_W-1:0] count_m1;
    logic [7:0]       rd_byte;
    logic             frame_ok;
    logic             commit;
    logic             emit;
    logic [15:0]      field_out [N_FIELDS];
    logic [7:0]       key_out;
    logic [15:0]      conc_out;
    logic             link_up_out;

    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_limit_reg  <= IDLE_LIMIT_RESET;
            link_limit_reg  <= LINK_LIMIT_RESET;
            header_byte_reg <= HEADER_BYTE_RESET;
            conc_floor_reg  <= CONC_FLOOR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_IDLE_LIMIT:  idle_limit_reg  <= cfg_data[7:0];
                CFG_LINK_LIMIT:  link_limit_reg  <= cfg_data;
                CFG_HEADER_BYTE: header_byte_reg <= cfg_data[7:0];
                CFG_CONC_FLOOR:  conc_floor_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Tick arithmetic: saturating link count and idle timer with its limit.
    assign is_tick     = (s_tuser == FUNC_TICK);
    assign link_inc    = (link_cnt_reg == LINK_COUNT_MAX) ? link_cnt_reg
                                                          : link_cnt_reg + 16'd1;
    assign link_over   = (link_inc > link_limit_reg);
    assign idle_inc    = {1'b0, timer_reg} + 9'd1;
    assign close_frame = is_tick && (count_reg != '0) && (idle_inc > {1'b0, idle_limit_reg});
    assign count_m1    = count_reg - IDX_W'(1);

    // An entry never written since reset reads as zero.
    assign rd_byte  = rd_vld_reg ? rd_data_reg : 8'h00;
    assign frame_ok = (hdr_reg == header_byte_reg) && (tail_reg == sum_reg);
    assign commit   = cmd.finish && frame_ok;
    assign emit     = (cmd.accept && !close_frame) || cmd.finish;

    // Field values shown with this result: fresh ones from a good frame.
    always_comb begin
        for (int f = 0; f < N_FIELDS; f++) begin
            field_out[f] = commit ? {cap_reg[2*f], cap_reg[2*f+1]} : fields_reg[f];
        end
        key_out = commit ? cap_reg[CAP_BYTES-1] : key_reg;
    end

    assign conc_out = (field_out[0] <= conc_floor_reg) ? conc_floor_reg : field_out[0];

    always_comb begin
        if (cmd.finish) begin
            link_up_out = frame_ok || link_flag_reg;
        end else if (is_tick && link_over) begin
            link_up_out = 1'b0;
        end else begin
            link_up_out = link_flag_reg;
        end
    end

    // Buffer write on a received byte, registered read during the walk.
    always_ff @(posedge aclk) begin
        if (cmd.accept && !is_tick) begin
            mem[count_reg] <= s_tdata;
        end
        if (cmd.walk_issue) begin
            rd_data_reg  <= mem[rd_idx_reg];
            rd_vld_reg   <= vld_reg[rd_idx_reg];
            rd_idx_q_reg <= rd_idx_reg;
        end
    end

    // Valid bits of the buffer entries.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (cmd.accept && !is_tick) begin
            vld_reg[count_reg] <= 1'b1;
        end
    end

    // Byte count and idle timer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            timer_reg <= '0;
        end else if (cmd.accept) begin
            if (!is_tick) begin
                count_reg <= (count_reg == LAST_SLOT) ? count_reg : count_reg + IDX_W'(1);
                timer_reg <= '0;
            end else if (count_reg != '0) begin
                if (close_frame) begin
                    count_reg <= '0;
                    timer_reg <= '0;
                end else begin
                    timer_reg <= idle_inc[7:0];
                end
            end
        end
    end

    // Link counter and link flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_cnt_reg  <= '0;
            link_flag_reg <= 1'b0;
        end else if (cmd.accept && is_tick) begin
            if (link_over) begin
                link_flag_reg <= 1'b0;
                link_cnt_reg  <= link_limit_reg;
            end else begin
                link_cnt_reg <= link_inc;
            end
        end else if (commit) begin
            link_cnt_reg  <= '0;
            link_flag_reg <= 1'b1;
        end
    end

    // Walk setup on a closing tick and read address stepping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            rd_dv_reg  <= 1'b0;
        end else begin
            rd_dv_reg <= cmd.walk_issue;
            if (cmd.accept && close_frame) begin
                rd_idx_reg <= '0;
            end else if (cmd.walk_issue) begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
        end
    end

    // Frame extent of the walk: through the last byte and the key byte.
    always_ff @(posedge aclk) begin
        if (cmd.accept && close_frame) begin
            len_m1_reg   <= count_m1;
            last_idx_reg <= (count_m1 > KEY_IDX) ? count_m1 : KEY_IDX;
        end
    end

    // Checksum, header, trailer and field byte capture.
    always_ff @(posedge aclk) begin
        if (cmd.accept && close_frame) begin
            sum_reg <= '0;
        end else if (rd_dv_reg) begin
            if (rd_idx_q_reg < len_m1_reg) begin
                sum_reg <= sum_reg + rd_byte;
            end
            if (rd_idx_q_reg == '0) begin
                hdr_reg <= rd_byte;
            end
            if (rd_idx_q_reg == len_m1_reg) begin
                tail_reg <= rd_byte;
            end
            for (int k = 0; k < CAP_BYTES; k++) begin
                if (rd_idx_q_reg == IDX_W'(FIELD_FIRST_BYTE + k)) begin
                    cap_reg[k] <= rd_byte;
                end
            end
        end
    end

    // Latched fields; the concentration is raised to the floor on every item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int f = 0; f < N_FIELDS; f++) begin
                fields_reg[f] <= '0;
            end
            key_reg <= '0;
        end else begin
            if (emit) begin
                fields_reg[0] <= conc_out;
            end
            if (commit) begin
                for (int f = 1; f < N_FIELDS; f++) begin
                    fields_reg[f] <= field_out[f];
                end
                key_reg <= key_out;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tuser_reg <= {link_up_out, commit, cmd.finish};
            m_tdata_reg <= {key_out, field_out[4], field_out[3], field_out[2],
                            field_out[1], conc_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Status toward the controller.
    assign stat.close_frame = close_frame;
    assign stat.walk_end    = (rd_idx_reg == last_idx_reg);
    assign stat.out_free    = !m_tvalid_reg || m_tready;

endmodule

FILE: design/idle_timeout_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// idle_timeout_frame_receiver_core: UART frame receiver with idle timeout
// Collects bytes into a frame buffer, closes the frame after an idle period
// of timer ticks, checks header and additive checksum, latches the fields
// of a good frame and tracks link status.
//
//  Channel  Dir  Handshake            Payload
//  s_       in   s_tvalid/s_tready    s_tdata: rx_byte; s_tuser: func
//  m_       out  m_tvalid/m_tready    m_tdata: six fields; m_tuser: flags
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A received byte or a tick that closes no frame writes its result when taken.
// A tick that closes a frame holds off new input while the checksum walk
// reads the buffer through its single registered read port.
// Reset clears the control state, the buffer valid bits, counters and fields.
// A result waits in the output register; a new transaction is taken once
// that register is empty or being read in the same cycle.
// ----------------------------------------------------------------------------
module idle_timeout_frame_receiver_core
    import ifr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    input  logic                   s_tuser,   // [0] func
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] concentration, [31:16] flow_value, [47:32] temperature,
    // [63:48] supply_12v, [79:64] mains_voltage, [87:80] power_key
    output logic [87:0]            m_tdata,
    output logic [2:0]             m_tuser,   // [0] frame_done, [1] frame_ok, [2] link_up
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ifr_cmd_t  cmd;
    ifr_stat_t stat;

    // Sequencing controller.
    ifr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath with buffer, counters and output register.
    ifr_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
